// ===== rtl/ccpf_pkg.sv =====
// Shared constants, codes, command type and address helpers for the code cache engine.
package ccpf_pkg;

   localparam int SETS        = 64;
   localparam int WAYS        = 4;
   localparam int BLOCK_BYTES = 64;
   localparam int ADDR_BITS   = 32;

   // Geometry constants are powers of two, so set and tag are plain bit fields.
   localparam int OFF_W  = $clog2(BLOCK_BYTES);
   localparam int SET_W  = (SETS > 1) ? $clog2(SETS) : 1;
   localparam int WAY_W  = $clog2(WAYS);
   localparam int TAG_W  = ADDR_BITS - OFF_W - SET_W;
   localparam int CNT_W  = $clog2(SETS + 1);
   localparam int ROW_W  = WAYS * TAG_W;
   localparam int SLOT_W = 8;
   localparam int SPROD_W = SET_W + WAY_W + 1;

   typedef enum logic [1:0] {
      KIND_LOOKUP = 2'd0,
      KIND_FILL   = 2'd1,
      KIND_UNPIN  = 2'd2,
      KIND_FLUSH  = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ST_HIT     = 3'd0,
      ST_MISS    = 3'd1,
      ST_PLACED  = 3'd2,
      ST_DROPPED = 3'd3,
      ST_DONE    = 3'd4
   } status_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic             capture;    // latch the request beat
      logic             rd_en;      // read one set's rows
      logic             rd_sweep;   // row address comes from the sweep counter
      logic [SET_W-1:0] sweep_set;
      logic             exec;       // lookup or fill on the rows just read
      logic             sweep_upd;  // flush or unpin the rows just read
      logic             clear;      // zero the entry state of the sweep set
      logic             rsp_done;   // load a done result
   } ccpf_cmd_type;

   function automatic logic [SET_W-1:0] set_of(input logic [31:0] addr);
      set_of = addr[OFF_W +: SET_W];
   endfunction

   function automatic logic [TAG_W-1:0] tag_of(input logic [31:0] addr);
      tag_of = addr[ADDR_BITS-1 : OFF_W + SET_W];
   endfunction

   function automatic logic [SLOT_W-1:0] slot_of(input logic [SET_W-1:0] set_idx,
                                                  input logic [WAY_W-1:0] way_idx);
      logic [SPROD_W-1:0] prod;
      prod = SPROD_W'(set_idx) * SPROD_W'(WAYS) + SPROD_W'(way_idx);
      slot_of = SLOT_W'(prod);
   endfunction

endpackage

// ===== rtl/ccpf_ctrl.sv =====
// Controller state machine: request sequencing, set sweeps and result handshake.
module ccpf_ctrl
   import ccpf_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic [1:0]   req_kind,
   output logic         req_stall,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output ccpf_cmd_type cmd
);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_READ,
      S_EXEC,
      S_SWEEP,
      S_RESP
   } state_type;

   state_type        state_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             rsp_valid_ff;
   logic             sweep_rd;
   logic             sweep_last;

   assign sweep_rd   = (cnt_ff < CNT_W'(SETS));
   assign sweep_last = (cnt_ff == CNT_W'(SETS));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            S_CLEAR: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == CNT_W'(SETS - 1)) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (req_valid) begin
                  cnt_ff <= '0;
                  if (kind_type'(req_kind) inside {KIND_UNPIN, KIND_FLUSH}) begin
                     state_ff <= S_SWEEP;
                  end else begin
                     state_ff <= S_READ;
                  end
               end
            end
            S_READ: begin
               state_ff <= S_EXEC;
            end
            S_EXEC: begin
               state_ff     <= S_RESP;
               rsp_valid_ff <= 1'b1;
            end
            S_SWEEP: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (sweep_last) begin
                  state_ff     <= S_RESP;
                  rsp_valid_ff <= 1'b1;
               end
            end
            S_RESP: begin
               if (!rsp_stall) begin
                  rsp_valid_ff <= 1'b0;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff     <= S_IDLE;
               rsp_valid_ff <= 1'b0;
            end
         endcase
      end
   end

   always_comb begin
      cmd           = '0;
      cmd.capture   = (state_ff == S_IDLE) && req_valid;
      cmd.rd_en     = (state_ff == S_READ) || ((state_ff == S_SWEEP) && sweep_rd);
      cmd.rd_sweep  = (state_ff == S_SWEEP);
      cmd.sweep_set = cnt_ff[SET_W-1:0];
      cmd.exec      = (state_ff == S_EXEC);
      cmd.sweep_upd = (state_ff == S_SWEEP) && (cnt_ff != '0);
      cmd.clear     = (state_ff == S_CLEAR);
      cmd.rsp_done  = (state_ff == S_SWEEP) && sweep_last;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> !rsp_valid)
      else $error("result appeared in the cycle after a request beat");

   a_one_rsp: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall) |=> !rsp_valid)
      else $error("more than one result beat for a request");

   a_no_accept_pending: assert property (@(posedge clock) disable iff (reset)
      !req_stall |-> !rsp_valid)
      else $error("request open while a result is pending");

endmodule

// ===== rtl/ccpf_dpath.sv =====
// Datapath: entry state memories, tag memory, way selection and the result register.
module ccpf_dpath
   import ccpf_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  ccpf_cmd_type      cmd,
   input  logic [1:0]        req_kind,
   input  logic [31:0]       req_address,
   output logic [2:0]        rsp_status,
   output logic [1:0]        rsp_way,
   output logic [SLOT_W-1:0] rsp_slot
);

   logic [WAYS-1:0]   valid_mem [SETS];
   logic [WAYS-1:0]   flag_mem  [SETS];
   logic [WAYS-1:0]   pin_mem   [SETS];
   logic [ROW_W-1:0]  tag_mem   [SETS];

   kind_type          kind_ff;
   logic [31:0]       addr_ff;
   logic [WAYS-1:0]   valid_row_ff;
   logic [WAYS-1:0]   flag_row_ff;
   logic [WAYS-1:0]   pin_row_ff;
   logic [ROW_W-1:0]  tag_row_ff;
   logic [SET_W-1:0]  cur_set_ff;
   status_type        status_ff;
   logic [WAY_W-1:0]  way_ff;
   logic [SLOT_W-1:0] slot_ff;

   logic [SET_W-1:0]  rd_set;
   logic [SET_W-1:0]  wr_set;
   logic [TAG_W-1:0]  cur_tag;
   logic [WAYS-1:0]   hit_vec;
   logic              hit_any;
   logic [WAY_W-1:0]  hit_way;
   logic              row_wr;
   logic [WAYS-1:0]   valid_row_in;
   logic [WAYS-1:0]   flag_row_in;
   logic [WAYS-1:0]   pin_row_in;
   logic              tag_wr;
   logic [ROW_W-1:0]  tag_row_in;
   logic              rsp_load;
   status_type        status_in;
   logic [WAY_W-1:0]  way_in;
   logic [SLOT_W-1:0] slot_in;

   assign rd_set  = cmd.rd_sweep ? cmd.sweep_set : set_of(addr_ff);
   assign wr_set  = cmd.clear ? cmd.sweep_set : cur_set_ff;
   assign cur_tag = tag_of(addr_ff);

   // Tag match against the rows read in the previous cycle; lowest way wins.
   always_comb begin
      hit_way = '0;
      for (int w = WAYS - 1; w >= 0; w--) begin
         hit_vec[w] = valid_row_ff[w] && (tag_row_ff[w*TAG_W +: TAG_W] == cur_tag);
         if (hit_vec[w]) begin
            hit_way = WAY_W'(w);
         end
      end
      hit_any = |hit_vec;
   end

   always_comb begin
      logic [WAYS-1:0]  v_row;
      logic [WAYS-1:0]  f_row;
      logic [WAYS-1:0]  p_row;
      logic [WAYS-1:0]  cand_inv;
      logic [WAYS-1:0]  cand_cold;
      logic [WAYS-1:0]  cand_free;
      logic [WAYS-1:0]  one_hot;
      logic [WAY_W-1:0] inv_way;
      logic [WAY_W-1:0] cold_way;
      logic [WAY_W-1:0] free_way;
      logic [WAY_W-1:0] fill_way;

      v_row     = valid_row_ff;
      f_row     = flag_row_ff;
      p_row     = pin_row_ff;
      cand_inv  = ~v_row;
      cand_cold = ~p_row & ~f_row;
      cand_free = ~p_row;
      inv_way   = '0;
      cold_way  = '0;
      free_way  = '0;
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (cand_inv[w]) begin
            inv_way = WAY_W'(w);
         end
         if (cand_cold[w]) begin
            cold_way = WAY_W'(w);
         end
         if (cand_free[w]) begin
            free_way = WAY_W'(w);
         end
      end
      if (|cand_inv) begin
         fill_way = inv_way;
      end else if (|cand_cold) begin
         fill_way = cold_way;
      end else begin
         fill_way = free_way;
      end

      row_wr       = 1'b0;
      valid_row_in = v_row;
      flag_row_in  = f_row;
      pin_row_in   = p_row;
      tag_wr       = 1'b0;
      tag_row_in   = tag_row_ff;
      rsp_load     = 1'b0;
      status_in    = ST_DONE;
      way_in       = '0;
      slot_in      = '0;
      one_hot      = '0;

      if (cmd.exec) begin
         rsp_load = 1'b1;
         case (kind_ff)
            KIND_LOOKUP: begin
               if (hit_any) begin
                  one_hot     = WAYS'(1) << hit_way;
                  flag_row_in = f_row | one_hot;
                  // Once every way has been read, only the latest keeps its flag.
                  if (&flag_row_in) begin
                     flag_row_in = one_hot;
                  end
                  row_wr    = 1'b1;
                  status_in = ST_HIT;
                  way_in    = hit_way;
                  slot_in   = slot_of(cur_set_ff, hit_way);
               end else begin
                  status_in = ST_MISS;
               end
            end
            KIND_FILL: begin
               if (|cand_free || |cand_inv) begin
                  one_hot      = WAYS'(1) << fill_way;
                  row_wr       = 1'b1;
                  valid_row_in = v_row | one_hot;
                  pin_row_in   = p_row | one_hot;
                  if (|cand_inv || !(|cand_cold)) begin
                     flag_row_in = f_row & ~one_hot;
                  end
                  tag_wr = 1'b1;
                  tag_row_in[fill_way*TAG_W +: TAG_W] = cur_tag;
                  status_in = ST_PLACED;
                  way_in    = fill_way;
                  slot_in   = slot_of(cur_set_ff, fill_way);
               end else begin
                  status_in = ST_DROPPED;
               end
            end
            default: begin
               status_in = ST_DONE;
            end
         endcase
      end

      // A sweep writes back each set in the cycle after reading it.
      if (cmd.sweep_upd) begin
         row_wr = 1'b1;
         if (kind_ff == KIND_UNPIN) begin
            pin_row_in = '0;
         end else begin
            valid_row_in = v_row & ~hit_vec;
         end
      end

      if (cmd.clear) begin
         row_wr       = 1'b1;
         valid_row_in = '0;
         flag_row_in  = '0;
         pin_row_in   = '0;
      end

      if (cmd.rsp_done) begin
         rsp_load  = 1'b1;
         status_in = ST_DONE;
      end
   end

   always_ff @(posedge clock) begin
      if (row_wr) begin
         valid_mem[wr_set] <= valid_row_in;
         flag_mem[wr_set]  <= flag_row_in;
         pin_mem[wr_set]   <= pin_row_in;
      end
      if (tag_wr) begin
         tag_mem[cur_set_ff] <= tag_row_in;
      end
      if (cmd.rd_en) begin
         valid_row_ff <= valid_mem[rd_set];
         flag_row_ff  <= flag_mem[rd_set];
         pin_row_ff   <= pin_mem[rd_set];
         tag_row_ff   <= tag_mem[rd_set];
         cur_set_ff   <= rd_set;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff <= kind_type'(req_kind);
         addr_ff <= req_address;
      end
      if (rsp_load) begin
         status_ff <= status_in;
         way_ff    <= way_in;
         slot_ff   <= slot_in;
      end
   end

   assign rsp_status = status_ff;
   assign rsp_way    = 2'(way_ff);
   assign rsp_slot   = slot_ff;

   a_hit_sets_flag: assert property (@(posedge clock) disable iff (reset)
      (cmd.exec && kind_ff == KIND_LOOKUP && hit_any) |-> (row_wr && flag_row_in[hit_way]))
      else $error("lookup hit left its way's read flag clear");

endmodule

// ===== rtl/code_cache_pin_flag_replacement.sv =====
// Top level of the code cache metadata and replacement engine.
//
//   Channel   Direction  Handshake              Payload
//   req_      in         req_valid / req_stall  req_kind[1:0], req_address[31:0]
//   rsp_      out        rsp_valid / rsp_stall  rsp_status[2:0], rsp_way[1:0], rsp_slot[7:0]
//
// From the request beat to rsp_valid, lookup and fill latch the request, do the registered
// read of the set's rows, and then decide.
// Flush and unpin walk every set through the single read port, one row a cycle, each
// row written back in the cycle after its read.
// One request is in flight at a time; req_stall stays high until its result beat is
// taken, and a stalled result holds in the output register.
// Reset is synchronous; after it is released a clearing pass over every set zeroes the
// valid, read-flag and pin bits with req_stall high. Tags are only compared
// on valid entries, so the tag memory needs no clearing.
module code_cache_pin_flag_replacement
   import ccpf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_kind,
   input  logic [31:0] req_address,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [1:0]  rsp_way,
   output logic [7:0]  rsp_slot
);

   // The controller sequences each request and the set sweeps; the datapath holds
   // all entry state and does the tag compare and way selection on its command.
   ccpf_cmd_type cmd;

   ccpf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_kind),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   ccpf_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_kind    (req_kind),
      .req_address (req_address),
      .rsp_status  (rsp_status),
      .rsp_way     (rsp_way),
      .rsp_slot    (rsp_slot)
   );

endmodule
